FILE: hdl/rs_pkg.sv
// ----------------------------------------------------------------------------
// rs_pkg
// Shared constants and types for the rank sort core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rs_pkg;

    localparam int DEPTH   = 64;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CNT_W-1:0]          count_t;

    // What one cell shows its neighbors
    typedef struct packed {
        value_t value;
        logic   valid;
        logic   ins;    // new value sorts strictly below the held one (or cell empty)
    } rs_link_t;

    // Chain-wide commands
    typedef struct packed {
        logic load;     // insert the broadcast value
        logic shift;    // move every entry one cell toward the head
    } rs_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/rs_cell.sv
// ----------------------------------------------------------------------------
// rs_cell
// One cell of the sorting chain: holds one entry, makes way for an insert,
// and passes its entry toward the head during drain.
// ----------------------------------------------------------------------------
`default_nettype none

module rs_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire rs_pkg::rs_ctrl_t ctrl,
    input  wire rs_pkg::value_t   in_value,
    input  wire rs_pkg::rs_link_t prev,
    input  wire rs_pkg::rs_link_t next,
    output rs_pkg::rs_link_t      self
);

    rs_pkg::value_t value_reg, value_next;
    logic           valid_reg, valid_next;
    logic           ins;

    // Equal values stay ahead of the newcomer, which keeps the order stable
    assign ins = !valid_reg || (in_value < value_reg);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.load && ins) begin
            if (prev.ins) begin
                value_next = prev.value;
                valid_next = prev.valid;
            end else begin
                value_next = in_value;
                valid_next = 1'b1;
            end
        end else if (ctrl.shift) begin
            value_next = next.value;
            valid_next = next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign self.value = value_reg;
    assign self.valid = valid_reg;
    assign self.ins   = ins;

endmodule

`default_nettype wire

FILE: hdl/rank_sort_core.sv
// ----------------------------------------------------------------------------
// rank_sort_core
// Stable ascending sort of up to DEPTH signed 32-bit values per batch.
// ----------------------------------------------------------------------------
// Values are taken one beat per cycle and inserted straight into a chain of
// DEPTH cells that always holds them in stable ascending order; every cell
// compares the incoming value with its own entry in the same cycle. The beat
// marked last closes the batch. The results then drain from the head cell, one
// beat per cycle while m_ready is high, and the input is not ready until the
// final result is taken. Values beyond DEPTH are dropped and m_overflow is set
// on every result of that batch. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_sort_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic signed [31:0]  s_value,
    input  wire logic                s_last,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_sorted_value,
    output logic                     m_last_out,
    output logic                     m_overflow
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_OUT  = 1'b1;

    logic             state_reg, state_next;
    rs_pkg::count_t   count_reg, count_next;
    logic             ovf_reg, ovf_next;
    rs_pkg::rs_ctrl_t ctrl;
    logic             in_beat, out_beat;

    rs_pkg::rs_link_t links [rs_pkg::DEPTH];

    assign s_ready  = (state_reg == ST_LOAD);
    assign m_valid  = (state_reg == ST_OUT);
    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        ctrl.load  = 1'b0;
        ctrl.shift = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                if (in_beat) begin
                    if (count_reg < rs_pkg::count_t'(rs_pkg::DEPTH)) begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        // chain full: drop the beat
                        ovf_next = 1'b1;
                    end
                    if (s_last) begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (out_beat) begin
                    ctrl.shift = 1'b1;
                    count_next = count_reg - 1'b1;
                    if (count_reg == rs_pkg::count_t'(1)) begin
                        state_next = ST_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    for (genvar k = 0; k < rs_pkg::DEPTH; k++) begin : g_cell
        rs_pkg::rs_link_t prev_link, next_link;

        if (k == 0) begin : g_head
            assign prev_link = '0;
        end else begin : g_body_prev
            assign prev_link = links[k-1];
        end

        if (k == rs_pkg::DEPTH - 1) begin : g_tail
            assign next_link = '0;
        end else begin : g_body_next
            assign next_link = links[k+1];
        end

        rs_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .in_value (s_value),
            .prev     (prev_link),
            .next     (next_link),
            .self     (links[k])
        );
    end

    assign m_sorted_value = links[0].value;
    assign m_last_out     = (count_reg == rs_pkg::count_t'(1));
    assign m_overflow     = ovf_reg;

`ifndef SYNTH
    a_out_has_entry : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (links[0].valid && count_reg != '0))
        else $error("result shown with empty head cell");

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rs_pkg::count_t'(rs_pkg::DEPTH))
        else $error("element count above depth");

    a_last_reopens : assert property (@(posedge aclk) disable iff (!aresetn)
        (out_beat && m_last_out) |=> (s_ready && !links[0].valid && !m_overflow))
        else $error("chain not empty after final result");

    a_tail_free : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && count_reg == '0) |-> !links[rs_pkg::DEPTH-1].valid)
        else $error("stale entry left in chain");
`endif

endmodule

`default_nettype wire
